// ----- hw/rtl/mcla_pkg.sv -----
// Shared types and constants for the MIDI channel lock allocator.
// No dependencies; used by mcla_cell, mcla_chain and the core top level.
package mcla_pkg;

    localparam int CHANNELS = 16;
    localparam int IDX_W    = $clog2(CHANNELS);
    localparam int NUM_W    = $clog2(CHANNELS + 1);
    localparam int CHAN_W   = 5;
    localparam int NOTE_W   = 8;
    localparam int CFG_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int RANGE_W  = (NUM_W > CHAN_W) ? NUM_W : CHAN_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_LOCK        = 2'd0,
        OP_RELEASE     = 2'd1,
        OP_SET_NOTES   = 2'd2,
        OP_SET_PROTECT = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOCK,
        CMD_RELEASE,
        CMD_NOTES,
        CMD_PROTECT
    } cmd_kind_t;

    // Per-channel state update, broadcast to every cell
    typedef struct packed {
        cmd_kind_t         kind;
        logic [IDX_W-1:0]  idx;
        logic [NOTE_W-1:0] value;
    } cmd_t;

    // Best-so-far record that walks down the chain, one cell per cycle.
    // p_*: best honoring protect marks, a_*: best ignoring them.
    typedef struct packed {
        logic              active;
        logic              p_valid;
        logic [IDX_W-1:0]  p_idx;
        logic [NOTE_W-1:0] p_notes;
        logic              a_valid;
        logic [IDX_W-1:0]  a_idx;
        logic [NOTE_W-1:0] a_notes;
    } scan_t;

    // Effective 1-based eligible range
    typedef struct packed {
        logic [RANGE_W-1:0] lo;
        logic [RANGE_W-1:0] hi;
    } range_t;

endpackage

// ----- hw/rtl/mcla_cell.sv -----
// One channel cell: holds lock, protect and note count of its channel and
// updates the passing scan record. Depends on mcla_pkg.
module mcla_cell (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [mcla_pkg::IDX_W-1:0] cell_idx,
    input  mcla_pkg::cmd_t             cmd,
    input  mcla_pkg::range_t           range,
    input  mcla_pkg::scan_t            scan_in,
    output mcla_pkg::scan_t            scan_out,
    output logic                       locked
);

    logic                         locked_reg;
    logic                         protect_reg;
    logic [mcla_pkg::NOTE_W-1:0]  notes_reg;
    mcla_pkg::scan_t              scan_reg;
    mcla_pkg::scan_t              scan_next;
    logic [mcla_pkg::RANGE_W-1:0] cell_num;
    logic                         eligible;
    logic                         hit;

    assign cell_num = mcla_pkg::RANGE_W'(cell_idx) + mcla_pkg::RANGE_W'(1);
    assign eligible = scan_in.active && !locked_reg
                      && (cell_num >= range.lo) && (cell_num <= range.hi);
    assign hit      = (cmd.idx == cell_idx);

    always_comb
    begin
        scan_next = scan_in;
        if (eligible)
        begin
            if (!scan_in.a_valid || notes_reg > scan_in.a_notes)
            begin
                scan_next.a_valid = 1'b1;
                scan_next.a_idx   = cell_idx;
                scan_next.a_notes = notes_reg;
            end
            if (!protect_reg && (!scan_in.p_valid || notes_reg > scan_in.p_notes))
            begin
                scan_next.p_valid = 1'b1;
                scan_next.p_idx   = cell_idx;
                scan_next.p_notes = notes_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            locked_reg  <= 1'b0;
            protect_reg <= 1'b0;
            notes_reg   <= '0;
            scan_reg    <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
            if (hit)
            begin
                case (cmd.kind)
                    mcla_pkg::CMD_LOCK:
                    begin
                        locked_reg <= 1'b1;
                        notes_reg  <= '0;
                    end
                    mcla_pkg::CMD_RELEASE:
                    begin
                        if (locked_reg)
                        begin
                            locked_reg <= 1'b0;
                            notes_reg  <= '0;
                        end
                    end
                    mcla_pkg::CMD_NOTES:   notes_reg   <= cmd.value;
                    mcla_pkg::CMD_PROTECT: protect_reg <= cmd.value[0];
                    default: ;
                endcase
            end
        end
    end

    assign scan_out = scan_reg;
    assign locked   = locked_reg;

endmodule

// ----- hw/rtl/mcla_chain.sv -----
// Row of CHANNELS channel cells; the scan record moves one cell per cycle.
// Depends on mcla_pkg and mcla_cell.
module mcla_chain (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mcla_pkg::cmd_t                cmd,
    input  mcla_pkg::range_t              range,
    input  mcla_pkg::scan_t               scan_in,
    output mcla_pkg::scan_t               scan_out,
    output logic [mcla_pkg::CHANNELS-1:0] locked
);

    mcla_pkg::scan_t link [mcla_pkg::CHANNELS+1];

    assign link[0] = scan_in;

    for (genvar i = 0; i < mcla_pkg::CHANNELS; i++)
    begin : g_cell
        mcla_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (mcla_pkg::IDX_W'(i)),
            .cmd      (cmd),
            .range    (range),
            .scan_in  (link[i]),
            .scan_out (link[i+1]),
            .locked   (locked[i])
        );
    end

    assign scan_out = link[mcla_pkg::CHANNELS];

endmodule

// ----- hw/rtl/midi_channel_lock_allocator_core.sv -----
// MIDI channel lock allocator, top level. Depends on mcla_pkg and mcla_chain.
// Release/set operations give their result in the cycle after start; a lock
// request gives it once the scan record has walked the whole cell chain, one
// channel per cycle, and the result has been registered. One transaction at a
// time while busy. The receiver cannot stall; done pulses for one cycle.
// Reset clears all lock, protect and note state and loads the range 1..16.
module midi_channel_lock_allocator_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     opcode,
    input  logic [mcla_pkg::CHAN_W-1:0]    channel,
    input  logic [mcla_pkg::NOTE_W-1:0]    value,
    output logic                           done,
    output logic [mcla_pkg::CHAN_W-1:0]    granted_channel,
    output logic                           accepted,
    input  logic                           cfg_we,
    input  logic [mcla_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mcla_pkg::CFG_W-1:0]     cfg_data
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t                        state_reg;
    logic                          done_reg;
    logic [mcla_pkg::CHAN_W-1:0]   granted_reg;
    logic                          accepted_reg;
    logic [mcla_pkg::CFG_W-1:0]    lowest_reg;
    logic [mcla_pkg::CFG_W-1:0]    highest_reg;

    mcla_pkg::cmd_t                cmd;
    mcla_pkg::range_t              range;
    mcla_pkg::scan_t               scan_in;
    mcla_pkg::scan_t               scan_out;
    logic [mcla_pkg::CHANNELS-1:0] locked;

    logic                          take;
    mcla_pkg::op_t                 op;
    logic [mcla_pkg::RANGE_W-1:0]  ch_wide;
    logic                          ch_ok;
    logic [mcla_pkg::IDX_W-1:0]    ch_idx;
    logic [mcla_pkg::RANGE_W-1:0]  hi_wide;
    logic                          pick_ok;
    logic [mcla_pkg::IDX_W-1:0]    pick_idx;
    logic                          op_accepted;

    assign take    = start && (state_reg == S_IDLE);
    assign op      = mcla_pkg::op_t'(opcode);
    assign ch_wide = mcla_pkg::RANGE_W'(channel);
    assign ch_ok   = (ch_wide >= mcla_pkg::RANGE_W'(1))
                     && (ch_wide <= mcla_pkg::RANGE_W'(mcla_pkg::CHANNELS));
    assign ch_idx  = mcla_pkg::IDX_W'(ch_wide - mcla_pkg::RANGE_W'(1));

    // Register clamping: lowest zero acts as 1, highest capped at CHANNELS
    assign hi_wide  = mcla_pkg::RANGE_W'(highest_reg);
    assign range.lo = (lowest_reg == '0) ? mcla_pkg::RANGE_W'(1)
                                         : mcla_pkg::RANGE_W'(lowest_reg);
    assign range.hi = (hi_wide > mcla_pkg::RANGE_W'(mcla_pkg::CHANNELS))
                      ? mcla_pkg::RANGE_W'(mcla_pkg::CHANNELS) : hi_wide;

    // Fall back to the protect-blind winner when no unprotected channel is free
    assign pick_ok  = scan_out.p_valid || scan_out.a_valid;
    assign pick_idx = scan_out.p_valid ? scan_out.p_idx : scan_out.a_idx;

    always_comb
    begin
        scan_in        = '0;
        scan_in.active = take && (op == mcla_pkg::OP_LOCK);
    end

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = mcla_pkg::CMD_NONE;
        op_accepted = 1'b0;
        if (state_reg == S_SCAN)
        begin
            if (scan_out.active && pick_ok)
            begin
                cmd.kind = mcla_pkg::CMD_LOCK;
                cmd.idx  = pick_idx;
            end
        end
        else if (take && ch_ok)
        begin
            cmd.idx   = ch_idx;
            cmd.value = value;
            case (op)
                mcla_pkg::OP_RELEASE:
                begin
                    cmd.kind    = mcla_pkg::CMD_RELEASE;
                    op_accepted = locked[ch_idx];
                end
                mcla_pkg::OP_SET_NOTES:
                begin
                    cmd.kind    = mcla_pkg::CMD_NOTES;
                    op_accepted = 1'b1;
                end
                mcla_pkg::OP_SET_PROTECT:
                begin
                    cmd.kind    = mcla_pkg::CMD_PROTECT;
                    op_accepted = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            done_reg     <= 1'b0;
            granted_reg  <= '0;
            accepted_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        if (op == mcla_pkg::OP_LOCK)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            done_reg     <= 1'b1;
                            granted_reg  <= '0;
                            accepted_reg <= op_accepted;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_out.active)
                    begin
                        state_reg    <= S_IDLE;
                        done_reg     <= 1'b1;
                        accepted_reg <= pick_ok;
                        granted_reg  <= pick_ok
                            ? mcla_pkg::CHAN_W'(mcla_pkg::RANGE_W'(pick_idx)
                                                + mcla_pkg::RANGE_W'(1))
                            : '0;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg  <= mcla_pkg::CFG_W'(1);
            highest_reg <= mcla_pkg::CFG_W'(16);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mcla_pkg::CFG_LOWEST:  lowest_reg  <= cfg_data;
                mcla_pkg::CFG_HIGHEST: highest_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    mcla_chain u_chain (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .range    (range),
        .scan_in  (scan_in),
        .scan_out (scan_out),
        .locked   (locked)
    );

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign granted_channel = granted_reg;
    assign accepted        = accepted_reg;

endmodule
